### rtl/tmrt_pkg.sv
`timescale 1ns / 1ps

package tmrt_pkg;

  localparam int MAX_EVENTS_DEF    = 256;
  localparam int ROWS_PER_BEAT_DEF = 48;

  localparam int NUM_W  = 68;
  localparam int DEN_W  = 40;
  localparam int PROD_W = 80;
  localparam int REM_W  = 41;

  localparam logic [1:0] OP_START = 2'd0;
  localparam logic [1:0] OP_SEG   = 2'd1;
  localparam logic [1:0] OP_ROW   = 2'd2;
  localparam logic [1:0] OP_TIME  = 2'd3;

  localparam logic [1:0] KIND_BUILD = 2'd0;
  localparam logic [1:0] KIND_TIME  = 2'd1;
  localparam logic [1:0] KIND_ROW   = 2'd2;
  localparam logic [1:0] KIND_FULL  = 2'd3;

  localparam logic [39:0] RATE_ONE = 40'h01_0000_0000;
  localparam logic [39:0] RATE_MAX = 40'h7F_FFFF_FFFF;
  localparam logic [39:0] RATE_MIN = 40'h80_0000_0000;
  localparam logic [49:0] SCALE_CAP = 50'h2_0000_0000_0000;
  localparam logic [NUM_W-1:0] NUM_SIXTY = NUM_W'(60) << 48;

  typedef enum logic {
    ARITH_MUL,
    ARITH_DIV
  } arith_mode_t;

  typedef struct packed {
    logic        start;
    arith_mode_t mode;
  } arith_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } arith_rsp_t;

  function automatic logic signed [47:0] sat48(input logic signed [51:0] v);
    logic signed [51:0] hi;
    logic signed [51:0] lo;
    hi = 52'sh0_7FFF_FFFF_FFFF;
    lo = -52'sh0_8000_0000_0000;
    if (v > hi) begin
      return 48'sh7FFF_FFFF_FFFF;
    end else if (v < lo) begin
      return 48'sh8000_0000_0000;
    end
    return v[47:0];
  endfunction

  // Rounded, capped magnitude of a product shifted right by sh bits.
  function automatic logic [49:0] scale_mag(input logic [PROD_W-1:0] p, input int sh);
    logic [PROD_W:0] t;
    t = ({1'b0, p} + ((PROD_W + 1)'(1) << (sh - 1))) >> sh;
    if (t > (PROD_W + 1)'(SCALE_CAP)) begin
      return SCALE_CAP;
    end
    return t[49:0];
  endfunction

endpackage

### rtl/tmrt_ram.sv
`timescale 1ns / 1ps

module tmrt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

### rtl/tmrt_arith.sv
`timescale 1ns / 1ps

module tmrt_arith (
  input  logic                         clk,
  input  logic                         rst,
  input  tmrt_pkg::arith_req_t         req,
  input  logic [tmrt_pkg::NUM_W-1:0]   opa,
  input  logic [tmrt_pkg::DEN_W-1:0]   opb,
  output tmrt_pkg::arith_rsp_t         rsp,
  output logic [tmrt_pkg::PROD_W-1:0]  prod,
  output logic [tmrt_pkg::NUM_W-1:0]   quot,
  output logic [tmrt_pkg::REM_W-1:0]   rem
);

  localparam int CNT_W = 7;
  localparam logic [CNT_W-1:0] MUL_STEPS = CNT_W'(tmrt_pkg::DEN_W);
  localparam logic [CNT_W-1:0] DIV_STEPS = CNT_W'(tmrt_pkg::NUM_W);

  tmrt_pkg::arith_mode_t mode;
  logic [CNT_W-1:0] cnt;
  logic [tmrt_pkg::PROD_W-1:0] mcand;
  logic [tmrt_pkg::DEN_W-1:0] mplier;
  logic [tmrt_pkg::DEN_W-1:0] den;
  logic [tmrt_pkg::REM_W-1:0] rs;
  logic qbit;
  logic [tmrt_pkg::REM_W-1:0] rem_next;

  assign rs       = {rem[tmrt_pkg::REM_W-2:0], quot[tmrt_pkg::NUM_W-1]};
  assign qbit     = rs >= {1'b0, den};
  assign rem_next = qbit ? rs - {1'b0, den} : rs;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp  <= '0;
      mode <= tmrt_pkg::ARITH_MUL;
      cnt  <= '0;
    end else begin
      rsp.done <= !req.start && rsp.busy && (cnt == CNT_W'(1));
      if (req.start) begin
        rsp.busy <= 1'b1;
        mode     <= req.mode;
        if (req.mode == tmrt_pkg::ARITH_MUL) begin
          prod   <= '0;
          mcand  <= tmrt_pkg::PROD_W'(opa[tmrt_pkg::DEN_W-1:0]);
          mplier <= opb;
          cnt    <= MUL_STEPS;
        end else begin
          quot <= opa;
          rem  <= '0;
          den  <= opb;
          cnt  <= DIV_STEPS;
        end
      end else if (rsp.busy) begin
        if (mode == tmrt_pkg::ARITH_MUL) begin
          if (mplier[0]) begin
            prod <= prod + mcand;
          end
          mcand  <= mcand << 1;
          mplier <= mplier >> 1;
        end else begin
          rem  <= rem_next;
          quot <= {quot[tmrt_pkg::NUM_W-2:0], qbit};
        end
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          rsp.busy <= 1'b0;
        end
      end
    end
  end

  assert property (@(posedge clk) disable iff (rst) req.start |-> !rsp.busy)
    else $error("Arithmetic unit started while busy.");

endmodule

### rtl/tempo_map_row_time_converter_top.sv
`timescale 1ns / 1ps
// Channel  Direction  Handshake              Word
// in       input      in_valid / in_stall    op, seg_row, has_tempo, tempo_bpm, stop_seconds,
//                                            delay_seconds, query_row, query_time
// out      output     out_valid / out_stall  result_kind, answer_time, answer_row, event_total
// cfg      input      cfg_wr_en              cfg_wr_data (song_offset)
//
// A start word goes straight to the response. A timing row runs a multiply on the shared
// multiply/divide unit, and a divide as well when it carries a nonzero tempo.
// A query runs a binary search and a fetch on the event memories as needed, an evaluation
// step, then, where needed, a multiply (row to time) or a divide (time to row), and then
// loads the result.
// Reset is synchronous; the event memories need no clearing after reset.
// A result held by out_stall waits in the output register while the next word is taken.

module tempo_map_row_time_converter_top #(
  parameter int MAX_EVENTS    = tmrt_pkg::MAX_EVENTS_DEF,
  parameter int ROWS_PER_BEAT = tmrt_pkg::ROWS_PER_BEAT_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_wr_en,
  input  logic [47:0]                       cfg_wr_data,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [1:0]                        op,
  input  logic [23:0]                       seg_row,
  input  logic                              has_tempo,
  input  logic signed [31:0]                tempo_bpm,
  input  logic signed [39:0]                stop_seconds,
  input  logic signed [39:0]                delay_seconds,
  input  logic [31:0]                       query_row,
  input  logic signed [47:0]                query_time,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [1:0]                        result_kind,
  output logic signed [47:0]                answer_time,
  output logic signed [32:0]                answer_row,
  output logic [$clog2(MAX_EVENTS+1)-1:0]   event_total
);

  localparam int AW = $clog2(MAX_EVENTS);
  localparam int CW = $clog2(MAX_EVENTS + 1);
  localparam logic [39:0] RATE_DEF = 40'(((64'd1 << 32) + ROWS_PER_BEAT / 2) / ROWS_PER_BEAT);

  typedef enum logic [3:0] {
    S_IDLE, S_SEG_MUL, S_SEG_DIV, S_SEG_HIT, S_SEG_END, S_SRCH_ADDR, S_SRCH_CMP,
    S_FETCH_ADDR, S_FETCH_WAIT, S_Q_EVAL, S_Q_MUL, S_Q_DIV, S_RESP
  } state_t;

  state_t state;

  logic [1:0]         r_op;
  logic [23:0]        r_row;
  logic               r_has_tempo;
  logic signed [31:0] r_bpm;
  logic signed [39:0] r_stop;
  logic signed [39:0] r_delay;
  logic [31:0]        r_qrow;
  logic signed [47:0] r_qtime;

  logic signed [47:0] song_offset;
  logic [CW-1:0]      stored_events;
  logic signed [47:0] running_time;
  logic signed [39:0] running_rate;
  logic [23:0]        last_event_row;

  logic signed [47:0] seg_start;
  logic signed [47:0] seg_hit;
  logic               mul_neg;

  logic [AW-1:0]      base;
  logic [CW-1:0]      count;
  logic [23:0]        erow;
  logic signed [47:0] ehit;
  logic signed [47:0] eend;
  logic signed [39:0] erate;

  logic [1:0]         res_kind;
  logic signed [47:0] res_time;
  logic signed [32:0] res_row;

  tmrt_pkg::arith_req_t ar_req;
  tmrt_pkg::arith_rsp_t ar_rsp;
  logic [tmrt_pkg::NUM_W-1:0]  ar_a;
  logic [tmrt_pkg::DEN_W-1:0]  ar_b;
  logic [tmrt_pkg::PROD_W-1:0] prod;
  logic [tmrt_pkg::NUM_W-1:0]  quot;
  logic [tmrt_pkg::REM_W-1:0]  rem;
  logic                        ar_start_next;

  logic [AW-1:0]  rd_addr;
  logic           ram_we;
  logic [23:0]    rd_row;
  logic [47:0]    rd_start;
  logic [47:0]    rd_hit;
  logic [47:0]    rd_end;
  logic [39:0]    rd_rate;

  logic [CW-1:0]      step;
  logic [CW-1:0]      mid_full;
  logic               le;
  logic signed [25:0] delta;
  logic [24:0]        delta_mag;
  logic [39:0]        rate_mag;
  logic [39:0]        erate_mag;
  logic [31:0]        bpm_mag;
  logic [39:0]        tempo_den;
  logic [39:0]        tempo_rate;
  logic [39:0]        neg_q;
  logic [49:0]        sc12_mag;
  logic [49:0]        sc20_mag;
  logic signed [51:0] sc12;
  logic signed [51:0] sc20;
  logic signed [47:0] start_val;
  logic signed [47:0] hit_val;
  logic signed [47:0] end_val;
  logic signed [47:0] qtime_val;
  logic [31:0]        rq;
  logic signed [48:0] tdiff;
  logic               q_over;
  logic               q_rnd;
  logic [40:0]        qq;
  logic [41:0]        row_sum;
  logic [31:0]        row_ans;

  assign in_stall = (state != S_IDLE);

  always_comb begin
    step      = count >> 1;
    mid_full  = CW'(base) + step;
    rd_addr   = (state == S_FETCH_ADDR) ? base : mid_full[AW-1:0];
    ram_we    = (state == S_SEG_END);
    le        = (r_op == tmrt_pkg::OP_ROW) ? ({rd_row, 8'd0} <= r_qrow)
                                           : ($signed(rd_start) <= r_qtime);
    delta     = $signed({2'b00, seg_row}) - $signed({2'b00, last_event_row});
    delta_mag = delta[25] ? 25'(-delta) : delta[24:0];
    rate_mag  = running_rate[39] ? 40'(-running_rate) : running_rate;
    erate_mag = erate[39] ? 40'(-erate) : erate;
    bpm_mag   = r_bpm[31] ? 32'(-r_bpm) : r_bpm;
    tempo_den = 40'(bpm_mag) * 40'(ROWS_PER_BEAT);
    neg_q     = (quot > tmrt_pkg::NUM_W'(tmrt_pkg::RATE_MIN)) ? tmrt_pkg::RATE_MIN
                                                               : quot[39:0];
    if (r_bpm[31]) begin
      tempo_rate = 40'(-neg_q);
    end else begin
      tempo_rate = (quot > tmrt_pkg::NUM_W'(tmrt_pkg::RATE_MAX)) ? tmrt_pkg::RATE_MAX
                                                                  : quot[39:0];
    end
    sc12_mag  = tmrt_pkg::scale_mag(prod, 12);
    sc20_mag  = tmrt_pkg::scale_mag(prod, 20);
    sc12      = mul_neg ? -$signed({2'b00, sc12_mag}) : $signed({2'b00, sc12_mag});
    sc20      = mul_neg ? -$signed({2'b00, sc20_mag}) : $signed({2'b00, sc20_mag});
    start_val = tmrt_pkg::sat48(52'(running_time) + sc12);
    hit_val   = tmrt_pkg::sat48(52'(seg_start) + 52'(r_delay));
    end_val   = tmrt_pkg::sat48(52'(seg_hit) + 52'(r_stop));
    qtime_val = tmrt_pkg::sat48(52'(eend) + sc20);
    rq        = {erow, 8'd0};
    tdiff     = 49'(r_qtime) - 49'(eend);
    q_over    = |quot[tmrt_pkg::NUM_W-1:40];
    q_rnd     = ({rem, 1'b0} >= {2'b00, erate});
    qq        = {1'b0, quot[39:0]} + 41'(q_rnd);
    row_sum   = 42'(rq) + 42'(qq);
    if (q_over || (qq > 41'hFFFF_FFFF) || (row_sum > 42'hFFFF_FFFF)) begin
      row_ans = 32'hFFFF_FFFF;
    end else begin
      row_ans = row_sum[31:0];
    end
    ar_start_next = ((state == S_IDLE) && in_valid && (op == tmrt_pkg::OP_SEG) &&
                     (stored_events < CW'(MAX_EVENTS))) ||
                    ((state == S_SEG_MUL) && ar_rsp.done && r_has_tempo &&
                     (r_bpm != '0)) ||
                    ((state == S_Q_EVAL) &&
                     ((r_op == tmrt_pkg::OP_ROW) ? (r_qrow > rq)
                                                : ((r_qtime > eend) && !erate[39] &&
                                                   (erate != '0))));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      out_valid      <= 1'b0;
      song_offset    <= '0;
      stored_events  <= '0;
      running_time   <= '0;
      running_rate   <= tmrt_pkg::RATE_ONE;
      last_event_row <= '0;
      ar_req         <= '0;
    end else begin
      ar_req.start <= ar_start_next;
      if (cfg_wr_en) begin
        song_offset <= cfg_wr_data;
      end
      if (out_valid && !out_stall && (state != S_RESP)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            r_op        <= op;
            r_row       <= seg_row;
            r_has_tempo <= has_tempo;
            r_bpm       <= tempo_bpm;
            r_stop      <= stop_seconds;
            r_delay     <= delay_seconds;
            r_qrow      <= query_row;
            r_qtime     <= query_time;
            res_time    <= '0;
            res_row     <= '0;
            unique case (op)
              tmrt_pkg::OP_START: begin
                res_kind       <= tmrt_pkg::KIND_BUILD;
                stored_events  <= '0;
                running_time   <= tmrt_pkg::sat48(-52'(song_offset));
                running_rate   <= tmrt_pkg::RATE_ONE;
                last_event_row <= '0;
                state          <= S_RESP;
              end
              tmrt_pkg::OP_SEG: begin
                if (stored_events >= CW'(MAX_EVENTS)) begin
                  res_kind <= tmrt_pkg::KIND_FULL;
                  state    <= S_RESP;
                end else begin
                  res_kind     <= tmrt_pkg::KIND_BUILD;
                  ar_req.mode  <= tmrt_pkg::ARITH_MUL;
                  ar_a         <= tmrt_pkg::NUM_W'(delta_mag);
                  ar_b         <= rate_mag;
                  mul_neg      <= delta[25] ^ running_rate[39];
                  state        <= S_SEG_MUL;
                end
              end
              default: begin
                base  <= '0;
                count <= stored_events;
                erow  <= '0;
                ehit  <= '0;
                eend  <= '0;
                erate <= RATE_DEF;
                if (stored_events == '0) begin
                  state <= S_Q_EVAL;
                end else if (stored_events > CW'(1)) begin
                  state <= S_SRCH_ADDR;
                end else begin
                  state <= S_FETCH_ADDR;
                end
              end
            endcase
          end
        end
        S_SEG_MUL: begin
          if (ar_rsp.done) begin
            seg_start <= start_val;
            if (!r_has_tempo) begin
              state <= S_SEG_HIT;
            end else if (r_bpm == '0) begin
              running_rate <= tmrt_pkg::RATE_MAX;
              state        <= S_SEG_HIT;
            end else begin
              ar_req.mode  <= tmrt_pkg::ARITH_DIV;
              ar_a         <= tmrt_pkg::NUM_SIXTY + tmrt_pkg::NUM_W'(tempo_den >> 1);
              ar_b         <= tempo_den;
              state        <= S_SEG_DIV;
            end
          end
        end
        S_SEG_DIV: begin
          if (ar_rsp.done) begin
            running_rate <= tempo_rate;
            state        <= S_SEG_HIT;
          end
        end
        S_SEG_HIT: begin
          seg_hit <= hit_val;
          state   <= S_SEG_END;
        end
        S_SEG_END: begin
          stored_events  <= stored_events + 1'b1;
          running_time   <= end_val;
          last_event_row <= r_row;
          state          <= S_RESP;
        end
        S_SRCH_ADDR: begin
          state <= S_SRCH_CMP;
        end
        S_SRCH_CMP: begin
          if (le) begin
            base  <= mid_full[AW-1:0];
            count <= count - step;
            state <= ((count - step) > CW'(1)) ? S_SRCH_ADDR : S_FETCH_ADDR;
          end else begin
            count <= step;
            state <= (step > CW'(1)) ? S_SRCH_ADDR : S_FETCH_ADDR;
          end
        end
        S_FETCH_ADDR: begin
          state <= S_FETCH_WAIT;
        end
        S_FETCH_WAIT: begin
          erow  <= rd_row;
          ehit  <= rd_hit;
          eend  <= rd_end;
          erate <= rd_rate;
          state <= S_Q_EVAL;
        end
        S_Q_EVAL: begin
          if (r_op == tmrt_pkg::OP_ROW) begin
            res_kind <= tmrt_pkg::KIND_TIME;
            if (r_qrow > rq) begin
              ar_req.mode  <= tmrt_pkg::ARITH_MUL;
              ar_a         <= tmrt_pkg::NUM_W'(r_qrow - rq);
              ar_b         <= erate_mag;
              mul_neg      <= erate[39];
              state        <= S_Q_MUL;
            end else begin
              res_time <= ehit;
              state    <= S_RESP;
            end
          end else begin
            res_kind <= tmrt_pkg::KIND_ROW;
            if ((r_qtime > eend) && !erate[39] && (erate != '0)) begin
              ar_req.mode  <= tmrt_pkg::ARITH_DIV;
              ar_a         <= {tdiff[47:0], 20'd0};
              ar_b         <= erate;
              state        <= S_Q_DIV;
            end else begin
              res_row <= {1'b0, rq};
              state   <= S_RESP;
            end
          end
        end
        S_Q_MUL: begin
          if (ar_rsp.done) begin
            res_time <= qtime_val;
            state    <= S_RESP;
          end
        end
        S_Q_DIV: begin
          if (ar_rsp.done) begin
            res_row <= {1'b0, row_ans};
            state   <= S_RESP;
          end
        end
        S_RESP: begin
          if (!out_valid || !out_stall) begin
            out_valid   <= 1'b1;
            result_kind <= res_kind;
            answer_time <= res_time;
            answer_row  <= res_row;
            event_total <= stored_events;
            state       <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  tmrt_arith u_arith (
    .clk  (clk),
    .rst  (rst),
    .req  (ar_req),
    .opa  (ar_a),
    .opb  (ar_b),
    .rsp  (ar_rsp),
    .prod (prod),
    .quot (quot),
    .rem  (rem)
  );

  tmrt_ram #(.WIDTH(24), .DEPTH(MAX_EVENTS)) u_row_ram (
    .clk (clk), .wr_en (ram_we), .wr_addr (stored_events[AW-1:0]), .wr_data (r_row),
    .rd_addr (rd_addr), .rd_data (rd_row)
  );

  tmrt_ram #(.WIDTH(48), .DEPTH(MAX_EVENTS)) u_start_ram (
    .clk (clk), .wr_en (ram_we), .wr_addr (stored_events[AW-1:0]), .wr_data (seg_start),
    .rd_addr (rd_addr), .rd_data (rd_start)
  );

  tmrt_ram #(.WIDTH(48), .DEPTH(MAX_EVENTS)) u_hit_ram (
    .clk (clk), .wr_en (ram_we), .wr_addr (stored_events[AW-1:0]), .wr_data (seg_hit),
    .rd_addr (rd_addr), .rd_data (rd_hit)
  );

  tmrt_ram #(.WIDTH(48), .DEPTH(MAX_EVENTS)) u_end_ram (
    .clk (clk), .wr_en (ram_we), .wr_addr (stored_events[AW-1:0]), .wr_data (end_val),
    .rd_addr (rd_addr), .rd_data (rd_end)
  );

  tmrt_ram #(.WIDTH(40), .DEPTH(MAX_EVENTS)) u_rate_ram (
    .clk (clk), .wr_en (ram_we), .wr_addr (stored_events[AW-1:0]), .wr_data (running_rate),
    .rd_addr (rd_addr), .rd_data (rd_rate)
  );

  assert property (@(posedge clk) disable iff (rst) stored_events <= CW'(MAX_EVENTS))
    else $error("Event count exceeds the table depth.");

  assert property (@(posedge clk) disable iff (rst)
    out_valid && (result_kind == tmrt_pkg::KIND_FULL) |-> event_total == CW'(MAX_EVENTS))
    else $error("Table full reported while the table has room.");

  assert property (@(posedge clk) disable iff (rst)
    out_valid && (result_kind != tmrt_pkg::KIND_TIME) |-> answer_time == '0)
    else $error("Time answer set on a word that is not a time answer.");

  assert property (@(posedge clk) disable iff (rst)
    (state == S_SRCH_CMP) |-> (count > CW'(1)) && (mid_full < stored_events))
    else $error("Search probe outside the stored events.");

endmodule
